### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the MD5 digest block.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle.
`define ASSERT_IMPLIES(LABEL, CLK, RST, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |-> (CONS)) \
    else $error("md5: same-cycle check failed");

// Implication in the next cycle.
`define ASSERT_NEXT(LABEL, CLK, RST, ANTE, CONS) \
  LABEL: assert property (@(posedge CLK) disable iff (RST) (ANTE) |=> (CONS)) \
    else $error("md5: next-cycle check failed");

`endif

### hw/rtl/md5_pkg.sv
// Shared types, constants and round tables of the MD5 digest block.
// Depends on nothing; used by md5_ram, md5_round, md5_message_digest and the testbench.
package md5_pkg;

  localparam int WORD_W    = 32;
  localparam int BUF_WORDS = 16;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [2:0] MAX_BYTES  = 3'd4;
  localparam logic [3:0] LEN_LO_IDX = 4'd14;
  localparam logic [3:0] LEN_HI_IDX = 4'd15;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [1:0] LAST_WORD  = 2'd3;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_item;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } dig_item_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRIME,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_FILL,
    ST_LEN_LO,
    ST_LEN_HI,
    ST_OUT
  } state_t;

  function automatic logic [31:0] sine_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;
      default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_s(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    case (r[5:4])
      2'd0:    g = r[3:0];
      2'd1:    g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2:    g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

endpackage

### hw/rtl/md5_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on md5_pkg for its default sizes.
module md5_ram #(
  parameter int WIDTH = md5_pkg::WORD_W,
  parameter int DEPTH = md5_pkg::BUF_WORDS
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/md5_round.sv
// One MD5 round step: boolean function, additions and rotation.
// Depends on md5_pkg for the round tables and the quad_t type.
module md5_round (
  input  logic [5:0]    rnd,
  input  md5_pkg::quad_t cur,
  input  logic [31:0]   m,
  output md5_pkg::quad_t nxt
);
  import md5_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      default: f = cur.c ^ (cur.b | ~cur.d);
    endcase
    sum   = cur.a + f + sine_k(rnd) + m;
    dbl   = {sum, sum} << rot_s(rnd);
    nxt.a = cur.d;
    nxt.b = cur.b + dbl[63:32];
    nxt.c = cur.b;
    nxt.d = cur.c;
  end

endmodule

### hw/rtl/md5_message_digest.sv
// MD5 digest engine: takes message bytes up to four to an item and returns the
// 128-bit digest as four little-endian words A to D after the last item.
// Depends on md5_pkg, md5_ram, md5_round and assert_macros.svh.
//
// An ordinary item is taken without holding the input. An item that
// completes a 64-byte block holds the input while the single round unit
// runs: a prime step fetches the first message word, then 64 rounds at one
// a cycle (each reads one word from the 16-word message buffer RAM), then a
// fold into the chaining words. The last item then pads: the pad word, zero
// words up to word 13, one more step to reach word 14, the two length words
// and one or two compressions, then the four digest items at up to one a
// cycle as the output drains; the next item is taken only after the last
// digest item has been loaded. The message buffer needs no clearing after
// reset.
module md5_message_digest (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 msg_valid,
  output logic                 msg_stall,
  input  md5_pkg::msg_item_t   msg,
  output logic                 dig_valid,
  input  logic                 dig_stall,
  output md5_pkg::dig_item_t   dig
);
  import md5_pkg::*;
  `include "assert_macros.svh"

  state_t      state, state_next;
  quad_t       chain, work, work_next;
  logic [5:0]  rnd;
  logic [5:0]  fill;
  logic [31:0] partial;
  logic [63:0] bit_len;
  logic        last_pend, pad_done, len_done;
  logic [1:0]  out_idx;

  logic        accept;
  logic [2:0]  n_bytes;
  logic [31:0] data_masked;
  logic [63:0] combined;
  logic [2:0]  total;
  logic        word_full;
  logic        block_wrap;
  logic        dig_load;
  logic [31:0] word_sel;

  logic        ram_we;
  logic [3:0]  ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  md5_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BUF_WORDS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  md5_round u_round (
    .rnd (rnd),
    .cur (work),
    .m   (ram_rdata),
    .nxt (work_next)
  );

  always_comb begin
    n_bytes = (msg.byte_count > MAX_BYTES) ? MAX_BYTES : msg.byte_count;
    for (int i = 0; i < 4; i++) begin
      data_masked[8*i +: 8] = (3'(i) < n_bytes) ? msg.data_word[8*i +: 8] : 8'h00;
    end
    combined   = ({32'd0, data_masked} << {fill[1:0], 3'b000}) | {32'd0, partial};
    total      = {1'b0, fill[1:0]} + n_bytes;
    word_full  = total[2];
    block_wrap = word_full && (fill[5:2] == LEN_HI_IDX);
  end

  always_comb begin
    case (out_idx)
      2'd0:    word_sel = chain.a;
      2'd1:    word_sel = chain.b;
      2'd2:    word_sel = chain.c;
      default: word_sel = chain.d;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (block_wrap) begin
            state_next = ST_PRIME;
          end else if (msg.last_item) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PRIME: state_next = ST_ROUND;
      ST_ROUND: begin
        if (rnd == LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (len_done) begin
          state_next = ST_OUT;
        end else if (last_pend && !pad_done) begin
          state_next = ST_PAD;
        end else if (last_pend) begin
          state_next = ST_FILL;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: state_next = (fill[5:2] == LEN_HI_IDX) ? ST_PRIME : ST_FILL;
      ST_FILL: begin
        if (fill[5:2] == LEN_LO_IDX) begin
          state_next = ST_LEN_LO;
        end else if (fill[5:2] == LEN_HI_IDX) begin
          state_next = ST_PRIME;
        end
      end
      ST_LEN_LO: state_next = ST_LEN_HI;
      ST_LEN_HI: state_next = ST_PRIME;
      ST_OUT: begin
        if (dig_load && (out_idx == LAST_WORD)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and buffer port control
  always_comb begin
    msg_stall = (state != ST_IDLE);
    accept    = msg_valid && (state == ST_IDLE);
    dig_load  = (state == ST_OUT) && (!dig_valid || !dig_stall);
    ram_we    = 1'b0;
    ram_waddr = fill[5:2];
    ram_wdata = combined[31:0];
    ram_raddr = msg_index((state == ST_ROUND) ? rnd + 6'd1 : rnd);
    unique case (state)
      ST_IDLE: ram_we = accept && word_full;
      ST_PAD: begin
        ram_we    = 1'b1;
        ram_wdata = partial | ({24'd0, PAD_BYTE} << {fill[1:0], 3'b000});
      end
      ST_FILL: begin
        ram_we    = (fill[5:2] != LEN_LO_IDX);
        ram_wdata = 32'd0;
      end
      ST_LEN_LO: begin
        ram_we    = 1'b1;
        ram_waddr = LEN_LO_IDX;
        ram_wdata = bit_len[31:0];
      end
      ST_LEN_HI: begin
        ram_we    = 1'b1;
        ram_waddr = LEN_HI_IDX;
        ram_wdata = bit_len[63:32];
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chain     <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
      rnd       <= 6'd0;
      fill      <= 6'd0;
      partial   <= 32'd0;
      bit_len   <= 64'd0;
      last_pend <= 1'b0;
      pad_done  <= 1'b0;
      len_done  <= 1'b0;
      out_idx   <= 2'd0;
      dig_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dig_valid && !dig_stall && !dig_load) begin
        dig_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            fill      <= fill + {3'd0, n_bytes};
            bit_len   <= bit_len + {58'd0, n_bytes, 3'b000};
            partial   <= word_full ? combined[63:32] : combined[31:0];
            last_pend <= msg.last_item;
          end
        end
        ST_PRIME: begin
          work <= chain;
          rnd  <= 6'd0;
        end
        ST_ROUND: begin
          work <= work_next;
          rnd  <= rnd + 6'd1;
        end
        ST_FOLD: begin
          chain.a <= chain.a + work.a;
          chain.b <= chain.b + work.b;
          chain.c <= chain.c + work.c;
          chain.d <= chain.d + work.d;
        end
        ST_PAD: begin
          fill     <= {fill[5:2] + 4'd1, 2'b00};
          partial  <= 32'd0;
          pad_done <= 1'b1;
        end
        ST_FILL: begin
          if (fill[5:2] != LEN_LO_IDX) begin
            fill <= {fill[5:2] + 4'd1, 2'b00};
          end
        end
        ST_LEN_LO: begin
        end
        ST_LEN_HI: len_done <= 1'b1;
        ST_OUT: begin
          if (dig_load) begin
            dig_valid <= 1'b1;
            dig       <= '{digest_word: word_sel, word_index: out_idx,
                           last_word: (out_idx == LAST_WORD)};
            out_idx   <= out_idx + 2'd1;
            if (out_idx == LAST_WORD) begin
              chain     <= '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
              fill      <= 6'd0;
              bit_len   <= 64'd0;
              last_pend <= 1'b0;
              pad_done  <= 1'b0;
              len_done  <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  `ASSERT_IMPLIES(a_no_write_in_compress, clk, rst, (state == ST_PRIME) || (state == ST_ROUND), !ram_we)
  `ASSERT_NEXT(a_round_ends, clk, rst, (state == ST_ROUND) && (rnd == LAST_ROUND), state == ST_FOLD)
  `ASSERT_NEXT(a_last_emits, clk, rst, dig_load && (out_idx == LAST_WORD), dig_valid && dig.last_word && (dig.word_index == LAST_WORD))
  `ASSERT_IMPLIES(a_len_after_pad, clk, rst, state == ST_LEN_LO, pad_done && last_pend && (fill[5:2] == LEN_LO_IDX))

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for md5_message_digest: streams byte messages as
// 32-bit items and checks every digest word against an in-bench MD5 model.
// Depends on md5_pkg and the md5_message_digest RTL.
module testbench;
  import md5_pkg::*;

  localparam int DIRECTED    = 24;
  localparam int RANDOM      = 150;
  localparam int CALM_AT     = DIRECTED + 110;
  localparam int HOLD_AT     = DIRECTED + 30;
  localparam int HOLD_CYCLES = 700;
  localparam int WATCHDOG    = 6000;
  localparam int DRAIN       = 200;

  localparam logic [31:0] ROUND_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam int SHIFT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  class digest_book;
    logic [31:0] chain [4];
    logic [31:0] block [16];
    int          fill;
    logic [63:0] bit_total;
    dig_item_t   pending [$];
    int          errors;
    int          digests;
    int          words_checked;

    function new();
      errors = 0;
      digests = 0;
      words_checked = 0;
      foreach (block[i]) block[i] = '0;
      restart();
    endfunction

    function void restart();
      chain[0] = IV_A;
      chain[1] = IV_B;
      chain[2] = IV_C;
      chain[3] = IV_D;
      fill = 0;
      bit_total = '0;
    endfunction

    function void compress();
      logic [31:0] a, b, c, d, f, t;
      int g, s, stage;
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        stage = r / 16;
        case (stage)
          0: begin f = (b & c) | (~b & d); g = r; end
          1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
          2: begin f = b ^ c ^ d;          g = (3 * r + 5) % 16; end
          default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
        endcase
        t = a + f + ROUND_K[r] + block[g];
        s = SHIFT_AMT[stage * 4 + r % 4];
        a = d;
        d = c;
        c = b;
        b = b + ((t << s) | (t >> (32 - s)));
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    function void push_byte(logic [7:0] value);
      block[fill / 4][(fill % 4) * 8 +: 8] = value;
      fill = (fill + 1) % 64;
      if (fill == 0) compress();
    endfunction

    function void note_item(msg_item_t it);
      int n;
      dig_item_t w;
      n = (it.byte_count > MAX_BYTES) ? 4 : int'(it.byte_count);
      for (int i = 0; i < n; i++) begin
        push_byte(it.data_word[8 * i +: 8]);
        bit_total += 64'd8;
      end
      if (!it.last_item) return;
      push_byte(PAD_BYTE);
      while (fill != 56) push_byte(8'h00);
      block[LEN_LO_IDX] = bit_total[31:0];
      block[LEN_HI_IDX] = bit_total[63:32];
      compress();
      for (int i = 0; i < 4; i++) begin
        w.digest_word = chain[i];
        w.word_index  = 2'(i);
        w.last_word   = (2'(i) == LAST_WORD);
        pending.push_back(w);
      end
      digests++;
      restart();
    endfunction

    function void check_digest(dig_item_t got);
      dig_item_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: digest item with none expected: word %h index %0d last %0b",
                 $time, got.digest_word, got.word_index, got.last_word);
        return;
      end
      want = pending.pop_front();
      words_checked++;
      if (got.digest_word !== want.digest_word) begin
        errors++;
        $display("%0t: digest_word expected %h actual %h", $time, want.digest_word,
                 got.digest_word);
      end
      if (got.word_index !== want.word_index) begin
        errors++;
        $display("%0t: word_index expected %0d actual %0d", $time, want.word_index,
                 got.word_index);
      end
      if (got.last_word !== want.last_word) begin
        errors++;
        $display("%0t: last_word expected %0b actual %0b", $time, want.last_word,
                 got.last_word);
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic      clk;
  logic      rst = 1'b1;
  logic      msg_valid = 1'b0;
  logic      msg_stall;
  msg_item_t msg = '0;
  logic      dig_valid;
  logic      dig_stall = 1'b0;
  dig_item_t dig;

  digest_book book = new();
  int         items_sent = 0;
  int         idle_cycles = 0;
  bit         calm = 1'b0;
  bit         sender_gaps = 1'b0;
  bit         hold_done = 1'b0;

  md5_message_digest dut (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic msg_item_t mk(logic [31:0] word, logic [2:0] count, logic last);
    msg_item_t it;
    it.data_word  = word;
    it.byte_count = count;
    it.last_item  = last;
    return it;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_item(msg_item_t it);
    int gap;
    if (sender_gaps && !calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 18);
      msg_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    msg       <= it;
    msg_valid <= 1'b1;
    @(posedge clk);
    while (msg_stall) @(posedge clk);
    book.note_item(it);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic random_message();
    int n;
    bit noisy;
    noisy = ($urandom_range(0, 7) == 0);
    sender_gaps = ($urandom_range(0, 2) != 0);
    n = noisy ? $urandom_range(0, 24) : $urandom_range(0, 20);
    for (int i = 0; i < n; i++)
      send_item(mk($urandom, noisy ? 3'($urandom_range(0, 7)) : MAX_BYTES, 1'b0));
    send_item(mk($urandom, noisy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 4)),
                 1'b1));
  endtask

  // Receiver: random stall bursts, one long hold-off, none near the end.
  initial begin
    int burst;
    forever begin
      @(negedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        dig_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        dig_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 18);
        dig_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        dig_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && dig_valid && !dig_stall) book.check_digest(dig);
  end

  always @(posedge clk) begin
    if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no progress for %0d cycles, %0d digest words pending", $time,
               WATCHDOG, book.outstanding());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(mk(32'h0000_0000, 3'd0, 1'b1));
    send_item(mk(32'hFFFF_FFFF, 3'd7, 1'b1));
    send_item(mk(32'h0000_00FF, 3'd1, 1'b0));
    send_item(mk(32'hFFFF_FFFF, 3'd2, 1'b0));
    send_item(mk(32'h1234_5678, 3'd3, 1'b1));
    sender_gaps = 1'b1;
    send_item(mk(32'hA5A5_A5A5, 3'd6, 1'b0));
    send_item(mk(32'h0000_0000, 3'd0, 1'b0));
    send_item(mk(32'h5A5A_5A5A, 3'd0, 1'b1));
    for (int i = 0; i < 15; i++) send_item(mk($urandom, 3'd4, 1'b0));
    send_item(mk($urandom, 3'd4, 1'b1));

    while (items_sent < DIRECTED + RANDOM) begin
      if (items_sent >= CALM_AT) calm = 1'b1;
      random_message();
    end
    msg_valid <= 1'b0;

    while (book.outstanding() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d items in messages of 0 to about 100 bytes, noisy counts included;",
             items_sent);
    $display("checked %0d digest words of %0d digests, %0d mismatches.",
             book.words_checked, book.digests, book.errors);
    if (book.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
